@@ design/grid_max_path_row_pick_limit_assert.svh @@
// Assertion macros used by the grid max-path checker.
`ifndef GRID_MAX_PATH_ROW_PICK_LIMIT_ASSERT_SVH
`define GRID_MAX_PATH_ROW_PICK_LIMIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GMP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid max path check failed");

// Next-cycle implication, ignored while reset is asserted.
`define GMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid max path check failed");

`endif

@@ design/gmp_pkg.sv @@
// Package: widths, types and constants for the grid max-path block.
`timescale 1ns / 1ps
`default_nettype none

package gmp_pkg;

  localparam int MAX_COLUMNS   = 4096;
  localparam int PICKS_PER_ROW = 3;
  localparam int NUM_TOTALS    = PICKS_PER_ROW + 1;

  localparam int VALUE_W = 30;
  localparam int TOTAL_W = 48;
  localparam int CFG_W   = 13;
  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W   = COL_W + 1;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef total_t [NUM_TOTALS-1:0] totals_t;

  localparam total_t TOTAL_MAX = '1;

  // What one cell leaves behind.
  typedef struct packed {
    totals_t right;
    total_t  down;
    logic    sat;
  } cell_res_t;

endpackage

`default_nettype wire

@@ design/gmp_cell.sv @@
// Per-cell update: entering totals, saturating picks, right and down totals.
`timescale 1ns / 1ps
`default_nettype none

module gmp_cell (
  input  wire gmp_pkg::value_t    value,
  input  wire gmp_pkg::total_t    above,
  input  wire gmp_pkg::totals_t   left,
  input  wire logic               first,
  output gmp_pkg::cell_res_t      res
);

  always_comb begin
    gmp_pkg::totals_t                               e;
    gmp_pkg::totals_t                               r;
    gmp_pkg::total_t [gmp_pkg::PICKS_PER_ROW-1:0]   t;
    logic [gmp_pkg::PICKS_PER_ROW-1:0]              t_sat;
    logic [gmp_pkg::TOTAL_W:0]                      sum;
    gmp_pkg::total_t                                m_dn;
    logic                                           take;

    take = (value != '0);

    for (int k = 0; k < gmp_pkg::NUM_TOTALS; k++) begin
      e[k] = first ? '0 : left[k];
    end
    if (above > e[0]) begin
      e[0] = above;
    end

    for (int k = 0; k < gmp_pkg::PICKS_PER_ROW; k++) begin
      sum = {1'b0, e[k]} + (gmp_pkg::TOTAL_W + 1)'(value);
      if (sum >= {1'b0, gmp_pkg::TOTAL_MAX}) begin
        t[k]     = gmp_pkg::TOTAL_MAX;
        t_sat[k] = 1'b1;
      end else begin
        t[k]     = sum[gmp_pkg::TOTAL_W-1:0];
        t_sat[k] = 1'b0;
      end
    end

    r = e;
    for (int k = 0; k < gmp_pkg::PICKS_PER_ROW; k++) begin
      if (take && (t[k] > r[k+1])) begin
        r[k+1] = t[k];
      end
    end

    // every candidate for the down total already sits in r
    m_dn = r[0];
    for (int k = 1; k < gmp_pkg::NUM_TOTALS; k++) begin
      if (r[k] > m_dn) begin
        m_dn = r[k];
      end
    end

    res.right = r;
    res.down  = m_dn;
    res.sat   = take && (|t_sat);
  end

endmodule

`default_nettype wire

@@ design/grid_max_path_row_pick_limit.sv @@
// Top level: grid max-path sum with a per-row pick limit, row buffer and result register.
// Takes one grid cell per clock in row-major order and may take a cell in every
// cycle; only a last cell that finds an earlier result still stalled waits in the
// cell stage and stalls the input. The result for a grid is registered when its
// end_of_grid cell leaves the cell stage. The cycle is set by the cell stage: three
// 48-bit saturating adds and a small max tree between the row-buffer read register
// and the totals registers.
// The row buffer is a single 4096 x 48 memory, read when a cell is taken and
// written when it leaves the cell stage; same-column back-to-back cells are
// forwarded. There is no clearing pass: a fill count marks which columns hold
// data for the current grid, so the block is ready straight after reset and
// straight after each result. Column count changes are taken between beats.
`timescale 1ns / 1ps
`default_nettype none

module grid_max_path_row_pick_limit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire gmp_pkg::value_t         in_cell_value,
  input  wire logic                    in_end_of_grid,

  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      gmp_pkg::total_t         out_best_total,
  output      logic                    out_saturated,

  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire gmp_pkg::cfg_t           cfg_columns_in_use
);

  gmp_pkg::cfg_t      cfg_cols_r;
  gmp_pkg::cnt_t      col_count;
  gmp_pkg::col_t      col_pos_r;
  gmp_pkg::col_t      col_pos_nxt;
  gmp_pkg::col_t      acc_col;
  gmp_pkg::cnt_t      col_inc;

  logic               s1_valid_r;
  gmp_pkg::value_t    s1_value_r;
  logic               s1_last_r;
  gmp_pkg::col_t      s1_col_r;
  logic               s1_byp_r;
  logic               s1_byp_nxt;
  gmp_pkg::total_t    byp_d_r;
  gmp_pkg::total_t    mem_q_r;

  gmp_pkg::cnt_t      fill_r;
  logic               sat_seen_r;
  gmp_pkg::totals_t   row_r;

  logic               out_valid_r;
  gmp_pkg::total_t    out_total_r;
  logic               out_sat_r;

  logic               out_free;
  logic               s1_retire;
  logic               in_acc;
  gmp_pkg::total_t    above;
  gmp_pkg::cell_res_t res;

  gmp_pkg::total_t    row_mem [gmp_pkg::MAX_COLUMNS];

  // effective column count: zero acts as one, clamp at the buffer depth
  always_comb begin
    if (cfg_cols_r == '0) begin
      col_count = gmp_pkg::CNT_W'(1);
    end else if (int'(cfg_cols_r) > gmp_pkg::MAX_COLUMNS) begin
      col_count = gmp_pkg::CNT_W'(gmp_pkg::MAX_COLUMNS);
    end else begin
      col_count = gmp_pkg::CNT_W'(cfg_cols_r);
    end
  end

  always_comb begin
    acc_col = ({1'b0, col_pos_r} >= col_count) ? '0 : col_pos_r;
    col_inc = {1'b0, acc_col} + gmp_pkg::CNT_W'(1);
    if (in_end_of_grid || (col_inc >= col_count)) begin
      col_pos_nxt = '0;
    end else begin
      col_pos_nxt = col_inc[gmp_pkg::COL_W-1:0];
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_retire = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall  = s1_valid_r && !s1_retire;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // cell leaving this cycle wrote the column now being read
  assign s1_byp_nxt = s1_retire && !s1_last_r && (s1_col_r == acc_col);

  always_comb begin
    if (s1_byp_r) begin
      above = byp_d_r;
    end else if ({1'b0, s1_col_r} < fill_r) begin
      above = mem_q_r;
    end else begin
      above = '0;
    end
  end

  gmp_cell u_cell (
    .value (s1_value_r),
    .above (above),
    .left  (row_r),
    .first (s1_col_r == '0),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (s1_retire && !s1_last_r) begin
      row_mem[s1_col_r] <= res.down;
    end
    if (in_acc) begin
      mem_q_r <= row_mem[acc_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r  <= gmp_pkg::CFG_W'(gmp_pkg::MAX_COLUMNS);
      col_pos_r   <= '0;
      s1_valid_r  <= 1'b0;
      fill_r      <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_cols_r <= cfg_columns_in_use;
      end
      if (in_acc) begin
        col_pos_r <= col_pos_nxt;
      end
      s1_valid_r <= in_acc || (s1_valid_r && !s1_retire);
      if (s1_retire) begin
        if (s1_last_r) begin
          fill_r     <= '0;
          sat_seen_r <= 1'b0;
        end else begin
          sat_seen_r <= sat_seen_r | res.sat;
          if ({1'b0, s1_col_r} >= fill_r) begin
            fill_r <= {1'b0, s1_col_r} + gmp_pkg::CNT_W'(1);
          end
        end
      end
      if (s1_retire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r <= in_cell_value;
      s1_last_r  <= in_end_of_grid;
      s1_col_r   <= acc_col;
      s1_byp_r   <= s1_byp_nxt;
      byp_d_r    <= res.down;
    end
    if (s1_retire) begin
      row_r <= res.right;
    end
    if (s1_retire && s1_last_r) begin
      out_total_r <= res.down;
      out_sat_r   <= sat_seen_r | res.sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_total_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

@@ design/gmp_checker.sv @@
// Port-level checker for the grid max-path block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_max_path_row_pick_limit_assert.svh"

module gmp_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic             in_end_of_grid,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire gmp_pkg::total_t  out_best_total,
  input  wire logic             out_saturated
);

  logic last_beat;

  assign last_beat = in_valid && !in_stall && in_end_of_grid;

  // a stalled result stays put
  `GMP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_best_total) && $stable(out_saturated))

  // a fresh result must follow an accepted last-cell beat
  `GMP_ASSERT_IMPLY(a_out_origin, clk, rst_n, $rose(out_valid), $past(last_beat, 2))

  // with the result slot empty and no last cell in the pipe, nothing appears
  `GMP_ASSERT_NEXT(a_no_spurious, clk, rst_n, !out_valid && !$past(last_beat), !out_valid)

endmodule

bind grid_max_path_row_pick_limit gmp_checker u_gmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_end_of_grid (in_end_of_grid),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_best_total (out_best_total),
  .out_saturated  (out_saturated)
);

`default_nettype wire
